// ===== src/ctenc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctenc_pkg
// shared constants, types and helpers of the columnar transposition encryptor
// ----------------------------------------------------------------------------
package ctenc_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int MSG_MAX_DEF = 48;

  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 64;
  localparam int CFG_IW    = 2;
  localparam int KLEN_W    = 5;
  localparam int SEED_W    = 16;
  localparam int KEY_BITS  = 128;
  localparam int KSEL_W    = 4;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_KEY_LEN  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_KEY_HIGH = 2'd2;
  localparam logic [CFG_IW-1:0] REG_PAD_SEED = 2'd3;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [11:0]       MOD_RECIP = 12'd2520;  // floor(2^16 / 26)
  localparam logic [15:0]       PAD_MOD   = 16'd26;
  localparam logic [7:0]        CHAR_A    = 8'd65;
  localparam logic [7:0]        LOW_A     = 8'd97;
  localparam logic [7:0]        LOW_Z     = 8'd122;
  localparam logic [7:0]        CASE_GAP  = 8'd32;

  typedef struct packed {
    logic start;
  } sort_ctl_t;

  typedef struct packed {
    logic done;
  } sort_stat_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    fold_upper = (c >= LOW_A && c <= LOW_Z) ? c - CASE_GAP : c;
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

endpackage

// ===== src/ctenc_buf.sv =====
// ----------------------------------------------------------------------------
// ctenc_buf
// text buffer: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ctenc_buf (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ctenc_pkg::BUF_AW-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic                         re,
  input  logic [ctenc_pkg::BUF_AW-1:0] raddr,
  output logic [7:0]                   rdata_r
);

  logic [7:0] mem [ctenc_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== src/ctenc_rank.sv =====
// ----------------------------------------------------------------------------
// ctenc_rank
// stable column ordering: one shared key comparator counts each column's rank
// ----------------------------------------------------------------------------
module ctenc_rank #(
  parameter int KEY_MAX = ctenc_pkg::KEY_MAX_DEF,
  parameter int LEN_W   = $clog2(KEY_MAX + 1),
  parameter int LEN_IW  = $clog2(KEY_MAX)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctenc_pkg::sort_ctl_t           ctl,
  output ctenc_pkg::sort_stat_t          stat,
  input  logic [ctenc_pkg::KEY_BITS-1:0] key_chars,
  input  logic [LEN_W-1:0]               len,
  input  logic [LEN_IW-1:0]              rd_idx,
  output logic [LEN_IW-1:0]              rd_col
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_LOAD = 2'd1;
  localparam logic [1:0] R_CMP  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [LEN_IW-1:0] i_r, j_r, cnt_r;
  logic [7:0]        ki_r;
  logic [LEN_IW-1:0] order_r [KEY_MAX];

  logic [LEN_IW-1:0]              len_m1;
  logic [LEN_IW-1:0]              addr;
  logic [ctenc_pkg::KSEL_W-1:0]   ksel;
  logic [7:0]                     kval;
  logic                           before_i;
  logic [LEN_IW-1:0]              cnt_sum;

  assign len_m1  = LEN_IW'(len - LEN_W'(1));
  assign addr    = (state_r == R_LOAD) ? i_r : j_r;
  assign ksel    = ctenc_pkg::KSEL_W'(addr);
  // single key port, shared by the load and compare steps
  assign kval    = ctenc_pkg::fold_upper(key_chars[8*ksel +: 8]);
  assign before_i = (kval < ki_r) || (kval == ki_r && j_r < i_r);
  assign cnt_sum = cnt_r + LEN_IW'(before_i);
  assign rd_col  = order_r[rd_idx];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE: if (ctl.start) state_nxt = R_LOAD;
      R_LOAD: state_nxt = R_CMP;
      R_CMP: begin
        if (j_r == len_m1) begin
          state_nxt = (i_r == len_m1) ? R_IDLE : R_LOAD;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= R_IDLE;
      stat.done <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stat.done <= (state_r == R_CMP) && (j_r == len_m1) && (i_r == len_m1);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        i_r <= '0;
      end
      R_LOAD: begin
        ki_r  <= kval;
        j_r   <= '0;
        cnt_r <= '0;
      end
      R_CMP: begin
        cnt_r <= cnt_sum;
        j_r   <= j_r + LEN_IW'(1);
        if (j_r == len_m1) begin
          order_r[cnt_sum] <= i_r;
          i_r              <= i_r + LEN_IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/columnar_transposition_encrypt.sv =====
// ----------------------------------------------------------------------------
// columnar_transposition_encrypt
// columnar transposition encryptor with case folding and lfsr letter padding
// ----------------------------------------------------------------------------
// Plaintext beats load one per cycle (lowercase folded to uppercase) into a
// 64-entry buffer; beats past MSG_MAX are dropped and flag the message. The
// beat with in_tlast closes the message and the block stops taking input
// until the last cipher beat has left. The closing work runs on one sequencer:
// a repeated subtract finds rows and remainder, each padding letter takes an
// lfsr step with reciprocal multiply and then a mod-26 correction and buffer
// write, the column ordering runs one shared key comparator over every pair
// of key columns, and emission reads each cipher beat through the registered
// buffer read port, column by column in key order, stalling while out_tready
// is low. The key length in effect at the closing beat is used; 0 acts as 1
// and values above KEY_MAX as KEY_MAX.
// ----------------------------------------------------------------------------
module columnar_transposition_encrypt #(
  parameter int KEY_MAX = ctenc_pkg::KEY_MAX_DEF,
  parameter int MSG_MAX = ctenc_pkg::MSG_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // plaintext stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] plain_byte
  input  logic                         in_tlast,   // final_byte
  // cipher stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] cipher_byte
  output logic                         out_tlast,  // end_of_cipher
  output logic [0:0]                   out_tuser,  // [0] overflowed
  // register writes
  input  logic                         cfg_we,
  input  logic [ctenc_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [ctenc_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int LEN_W  = $clog2(KEY_MAX + 1);
  localparam int LEN_IW = $clog2(KEY_MAX);
  localparam int CW     = ctenc_pkg::CNT_W;
  localparam int AW     = ctenc_pkg::BUF_AW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_PADA  = 4'd2;
  localparam logic [3:0] S_PADB  = 4'd3;
  localparam logic [3:0] S_SORT  = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_COL   = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_SHOW  = 4'd8;

  // configuration registers
  logic [ctenc_pkg::KLEN_W-1:0] key_len_r;
  logic [63:0]                  key_lo_r, key_hi_r;
  logic [ctenc_pkg::SEED_W-1:0] seed_r;

  // sequencer state
  logic [3:0]                   state_r, state_nxt;
  logic [CW-1:0]                fill_r;     // buffer fill, then write pointer for padding
  logic                         drop_r;     // message lost bytes past capacity
  logic [ctenc_pkg::SEED_W-1:0] lfsr_r;
  logic [LEN_W-1:0]             len_r;      // key length latched at closing beat
  logic [CW-1:0]                rem_r;      // remainder of repeated subtract
  logic [CW-1:0]                rows_r;
  logic [LEN_W-1:0]             pad_cnt_r;
  logic [11:0]                  q_r;        // quotient estimate of lfsr / 26
  logic [LEN_IW-1:0]            k_r;        // output column position
  logic [CW-1:0]                row_r;
  logic [AW-1:0]                pos_r;      // buffer address of current cipher beat
  logic                         last_r;

  logic                         in_acc, out_acc;
  logic                         has_room;
  logic [ctenc_pkg::KLEN_W-1:0] len_eff;
  logic [ctenc_pkg::SEED_W-1:0] seed_eff;
  logic [ctenc_pkg::SEED_W-1:0] lfsr_stp;
  logic [27:0]                  q_prod;
  logic [15:0]                  rem_raw;
  logic [4:0]                   pad_rem;
  logic [CW-1:0]                len_ext;
  logic [CW-1:0]                pad_need;
  logic                         col_end, msg_end;

  logic                         buf_we;
  logic [7:0]                   buf_wdata;
  logic [LEN_IW-1:0]            col;
  ctenc_pkg::sort_ctl_t         sort_ctl;
  ctenc_pkg::sort_stat_t        sort_stat;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_SHOW);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tlast  = last_r;
  assign out_tuser  = drop_r;

  assign has_room = (fill_r < CW'(MSG_MAX));
  assign seed_eff = (seed_r == '0) ? ctenc_pkg::SEED_W'(1) : seed_r;

  // clamp key length into 1..KEY_MAX
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = ctenc_pkg::KLEN_W'(1);
    end else if (key_len_r > ctenc_pkg::KLEN_W'(KEY_MAX)) begin
      len_eff = ctenc_pkg::KLEN_W'(KEY_MAX);
    end else begin
      len_eff = key_len_r;
    end
  end

  // padding letter: lfsr mod 26 by reciprocal multiply, one correction step
  assign lfsr_stp = ctenc_pkg::lfsr_step(lfsr_r);
  assign q_prod   = 28'(lfsr_stp) * 28'(ctenc_pkg::MOD_RECIP);
  assign rem_raw  = lfsr_r - 16'(q_r) * ctenc_pkg::PAD_MOD;
  assign pad_rem  = (rem_raw >= ctenc_pkg::PAD_MOD) ? 5'(rem_raw - ctenc_pkg::PAD_MOD)
                                                    : 5'(rem_raw);

  assign len_ext  = CW'(len_r);
  assign pad_need = len_ext - rem_r;

  assign col_end = (row_r == rows_r - CW'(1));
  assign msg_end = col_end && (k_r == LEN_IW'(len_r - LEN_W'(1)));

  assign buf_we    = (in_acc && has_room) || (state_r == S_PADB);
  assign buf_wdata = (state_r == S_PADB) ? ctenc_pkg::CHAR_A + 8'(pad_rem)
                                         : ctenc_pkg::fold_upper(in_tdata);

  assign sort_ctl.start = (state_r == S_SORT);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= ctenc_pkg::KLEN_W'(1);
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      seed_r    <= ctenc_pkg::SEED_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        ctenc_pkg::REG_KEY_LEN:  key_len_r <= cfg_wdata[ctenc_pkg::KLEN_W-1:0];
        ctenc_pkg::REG_KEY_LOW:  key_lo_r  <= cfg_wdata;
        ctenc_pkg::REG_KEY_HIGH: key_hi_r  <= cfg_wdata;
        ctenc_pkg::REG_PAD_SEED: seed_r    <= cfg_wdata[ctenc_pkg::SEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_tlast) state_nxt = S_DIV;
      S_DIV: begin
        if (rem_r < len_ext) begin
          state_nxt = (rem_r == '0) ? S_SORT : S_PADA;
        end
      end
      S_PADA:  state_nxt = S_PADB;
      S_PADB:  state_nxt = (pad_cnt_r == LEN_W'(1)) ? S_SORT : S_PADA;
      S_SORT:  state_nxt = S_SWAIT;
      S_SWAIT: if (sort_stat.done) state_nxt = S_COL;
      S_COL:   state_nxt = S_RD;
      S_RD:    state_nxt = S_SHOW;
      S_SHOW: begin
        if (out_acc) begin
          if (msg_end) begin
            state_nxt = S_IDLE;
          end else if (col_end) begin
            state_nxt = S_COL;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      drop_r  <= 1'b0;
      lfsr_r  <= ctenc_pkg::SEED_W'(1);
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // message start reloads the padding lfsr
            if (fill_r == '0) lfsr_r <= seed_eff;
            if (has_room) begin
              fill_r <= fill_r + CW'(1);
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        S_PADA: lfsr_r <= lfsr_stp;
        S_PADB: fill_r <= fill_r + CW'(1);
        S_SHOW: begin
          if (out_acc && msg_end) begin
            fill_r <= '0;
            drop_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers of the closing work
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        len_r  <= LEN_W'(len_eff);
        rem_r  <= has_room ? fill_r + CW'(1) : fill_r;
        rows_r <= '0;
      end
      S_DIV: begin
        if (rem_r >= len_ext) begin
          rem_r  <= rem_r - len_ext;
          rows_r <= rows_r + CW'(1);
        end else if (rem_r != '0) begin
          // a partial last row gets padded to a full one
          rows_r    <= rows_r + CW'(1);
          pad_cnt_r <= LEN_W'(pad_need);
        end
        k_r <= '0;
      end
      S_PADA: q_r <= q_prod[27:16];
      S_PADB: pad_cnt_r <= pad_cnt_r - LEN_W'(1);
      S_COL: begin
        pos_r <= AW'(col);
        row_r <= '0;
      end
      S_RD: last_r <= msg_end;
      S_SHOW: begin
        if (out_acc) begin
          if (col_end) begin
            k_r <= k_r + LEN_IW'(1);
          end else begin
            pos_r <= pos_r + AW'(len_r);
            row_r <= row_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  ctenc_buf u_buf (
    .clk     (clk),
    .we      (buf_we),
    .waddr   (fill_r[AW-1:0]),
    .wdata   (buf_wdata),
    .re      (state_r == S_RD),
    .raddr   (pos_r),
    .rdata_r (out_tdata)
  );

  ctenc_rank #(
    .KEY_MAX (KEY_MAX),
    .LEN_W   (LEN_W),
    .LEN_IW  (LEN_IW)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sort_ctl),
    .stat      (sort_stat),
    .key_chars ({key_hi_r, key_lo_r}),
    .len       (len_r),
    .rd_idx    (k_r),
    .rd_col    (col)
  );

endmodule

// ===== src/ctenc_checker.sv =====
// ----------------------------------------------------------------------------
// ctenc_checker
// port-level checks of the encryptor, bound to the top level
// ----------------------------------------------------------------------------
module ctenc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // stalled cipher beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("cipher beat changed while stalled");

  // no plaintext taken while cipher is pending
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during emission");

  // closing beat stops input intake
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after closing beat");

  // last cipher beat returns the block to idle
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("block not idle after last cipher beat");

  // overflow mark is constant across one message
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> $stable(out_tuser))
    else $error("overflow mark changed within a message");

endmodule

bind columnar_transposition_encrypt ctenc_checker u_ctenc_checker (.*);
